// ===== hw/rtl/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern scanner.
`default_nettype none

package wbps_pkg;

   localparam int unsigned PATTERN_MAX_DEFAULT = 32;
   localparam int unsigned CSR_LEN_W           = 6;
   localparam int unsigned ADDR_W              = 32;
   localparam int unsigned ENTRY_W             = 9;
   localparam logic [CSR_LEN_W-1:0] CSR_LEN_RESET = CSR_LEN_W'(1);

   typedef enum logic {
      ACTION_LOAD = 1'b0,
      ACTION_SCAN = 1'b1
   } action_type;

   typedef struct packed {
      action_type        action;
      logic [4:0]        entry_index;
      logic [7:0]        entry_byte;
      logic              entry_wild;
      logic [7:0]        data_byte;
      logic [ADDR_W-1:0] byte_address;
      logic              region_last;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } rsp_type;

   typedef struct packed {
      logic       wild;
      logic [7:0] value;
   } pattern_entry_type;

   typedef struct packed {
      pattern_entry_type entry;
      logic              in_use;
   } lane_type;

endpackage

`default_nettype wire

// ===== hw/rtl/wbps_cell.sv =====
// Window cell: holds one window byte, passes it on, compares the incoming byte.
`default_nettype none

module wbps_cell (
   input  wire                 clock,
   input  wire                 shift_en,
   input  wire [7:0]           byte_prev,
   input  wbps_pkg::lane_type  lane,
   output logic [7:0]          byte_ff,
   output logic                hit
);
   import wbps_pkg::*;

   logic [7:0] byte_in;

   assign byte_in = shift_en ? byte_prev : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign hit = !lane.in_use || lane.entry.wild || (lane.entry.value == byte_prev);

endmodule

`default_nettype wire

// ===== hw/rtl/wbps_pattern.sv =====
// Pattern store with alignment of entries onto the window cells.
`default_nettype none

module wbps_pattern #(
   parameter int unsigned PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEFAULT,
   parameter int unsigned LEN_W       = $clog2(PATTERN_MAX + 1)
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 load_en,
   input  wire [4:0]           load_index,
   input  wbps_pkg::pattern_entry_type load_entry,
   input  wire [LEN_W-1:0]     len_eff,
   output wbps_pkg::lane_type  lanes [PATTERN_MAX]
);
   import wbps_pkg::*;

   localparam int unsigned FLAT_W = PATTERN_MAX * ENTRY_W;

   pattern_entry_type  pattern_ff [PATTERN_MAX];
   pattern_entry_type  pattern_in [PATTERN_MAX];
   logic [FLAT_W-1:0]  flat_rev;
   logic [FLAT_W-1:0]  flat_aligned;
   logic [LEN_W-1:0]   shamt;

   always_comb begin
      for (int k = 0; k < int'(PATTERN_MAX); k++) begin
         pattern_in[k] = pattern_ff[k];
         if (load_en && ({27'd0, load_index} == 32'(k))) begin
            pattern_in[k] = load_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < int'(PATTERN_MAX); k++) begin
            pattern_ff[k] <= '0;
         end
      end else begin
         pattern_ff <= pattern_in;
      end
   end

   // cell j pairs with pattern entry len-1-j
   always_comb begin
      for (int k = 0; k < int'(PATTERN_MAX); k++) begin
         flat_rev[k*ENTRY_W +: ENTRY_W] = pattern_ff[int'(PATTERN_MAX) - 1 - k];
      end
   end

   assign shamt        = LEN_W'(PATTERN_MAX) - len_eff;
   assign flat_aligned = flat_rev >> (32'(shamt) * ENTRY_W);

   always_comb begin
      for (int j = 0; j < int'(PATTERN_MAX); j++) begin
         lanes[j].entry  = flat_aligned[j*ENTRY_W +: ENTRY_W];
         lanes[j].in_use = (32'(j) < 32'(len_eff));
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/wildcard_byte_pattern_scan.sv =====
// Top level of the wildcard byte pattern scanner.
// A result is registered and presented in the cycle after the scan transfer that causes it.
// Throughput: one item per cycle unless stalled; a chain of window cells compares all positions at once.
// The input stays ready while the single output register is empty or draining.
// Reset: pattern entries clear to zero, pattern length returns to 1, window empties.
`default_nettype none

module wildcard_byte_pattern_scan #(
   parameter int unsigned PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wbps_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output wbps_pkg::rsp_type                  rsp_data,
   input  wire                                csr_we,
   input  wire [wbps_pkg::CSR_LEN_W-1:0]      csr_wdata
);
   import wbps_pkg::*;

   localparam int unsigned LEN_W  = $clog2(PATTERN_MAX + 1);
   localparam int unsigned WIDE_W = (LEN_W > CSR_LEN_W) ? LEN_W : CSR_LEN_W;

   logic [CSR_LEN_W-1:0] csr_len_ff;
   logic [CSR_LEN_W-1:0] csr_len_in;
   logic [LEN_W-1:0]     len_eff;
   logic [LEN_W-1:0]     fill_ff;
   logic [LEN_W-1:0]     fill_in;
   logic [LEN_W-1:0]     fill_inc;
   logic                 reported_ff;
   logic                 reported_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_data_in;

   logic                 accept;
   logic                 load_en;
   logic                 scan_en;
   logic                 match;
   logic                 emit;
   logic [PATTERN_MAX-1:0] hit;
   logic [7:0]           cell_byte [PATTERN_MAX];
   lane_type             lanes [PATTERN_MAX];
   pattern_entry_type    load_entry;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign load_en   = accept && (req_data.action == ACTION_LOAD);
   assign scan_en   = accept && (req_data.action == ACTION_SCAN);

   assign csr_len_in = csr_we ? csr_wdata : csr_len_ff;

   always_comb begin
      if (csr_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (WIDE_W'(csr_len_ff) > WIDE_W'(PATTERN_MAX)) begin
         len_eff = LEN_W'(PATTERN_MAX);
      end else begin
         len_eff = LEN_W'(csr_len_ff);
      end
   end

   assign load_entry.wild  = req_data.entry_wild;
   assign load_entry.value = req_data.entry_byte;

   wbps_pattern #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W)
   ) u_pattern (
      .clock      (clock),
      .reset      (reset),
      .load_en    (load_en),
      .load_index (req_data.entry_index),
      .load_entry (load_entry),
      .len_eff    (len_eff),
      .lanes      (lanes)
   );

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      wbps_cell u_cell (
         .clock     (clock),
         .shift_en  (scan_en),
         .byte_prev ((j == 0) ? req_data.data_byte : cell_byte[(j == 0) ? 0 : j - 1]),
         .lane      (lanes[j]),
         .byte_ff   (cell_byte[j]),
         .hit       (hit[j])
      );
   end

   assign fill_inc = (fill_ff == LEN_W'(PATTERN_MAX)) ? fill_ff : fill_ff + LEN_W'(1);
   assign match    = (fill_inc >= len_eff) && (&hit);
   assign emit     = scan_en && !reported_ff && (match || req_data.region_last);

   always_comb begin
      fill_in     = fill_ff;
      reported_in = reported_ff;
      if (scan_en) begin
         if (req_data.region_last) begin
            fill_in     = '0;
            reported_in = 1'b0;
         end else begin
            fill_in     = fill_inc;
            reported_in = reported_ff || match;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.found = match;
         rsp_data_in.match_address = match ?
            (req_data.byte_address - ADDR_W'(len_eff - LEN_W'(1))) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_len_ff   <= CSR_LEN_RESET;
         fill_ff      <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_len_ff   <= csr_len_in;
         fill_ff      <= fill_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wbps_checker.sv =====
// Port-level assertions for the wildcard byte pattern scanner, bound to the top level.
`default_nettype none

module wbps_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  wbps_pkg::req_type  req_data,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  wbps_pkg::rsp_type  rsp_data
);
   import wbps_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.match_address == '0)
      else $error("not-found result carries a nonzero address");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with the output free");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.action == ACTION_LOAD
      |=> !rsp_valid || $past(rsp_valid && !rsp_ready))
      else $error("load transfer produced a result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== sim/tb_wildcard_byte_pattern_scan.sv =====
// Testbench for wildcard_byte_pattern_scan: directed and random regions checked against a predictor.
module tb_wildcard_byte_pattern_scan;
   timeunit 1ns;
   timeprecision 1ps;

   import wbps_pkg::*;

   localparam int unsigned WIN_DEPTH    = PATTERN_MAX_DEFAULT;
   localparam int unsigned IDLE_LIMIT   = 1000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned RANDOM_ITEMS = 1930;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_LEN_W-1:0] csr_wdata = '0;

   // predictor state
   pattern_entry_type    pattern_mem [WIN_DEPTH];
   logic [7:0]           recent_bytes [WIN_DEPTH];
   int unsigned          fill_count;
   logic                 match_reported;
   logic [CSR_LEN_W-1:0] scan_len;
   rsp_type              pending_matches [$];

   // stimulus-side copy of the pattern, used to plant matches
   logic [7:0]           plan_byte [WIN_DEPTH];
   logic                 plan_wild [WIN_DEPTH];

   int unsigned          burst_left    = 0;
   int unsigned          gap_max       = 3;
   logic                 stall_on      = 1'b1;
   int unsigned          ready_hold    = 0;
   int unsigned          idle_cycles   = 0;
   int unsigned          stim_count    = 0;
   int unsigned          scan_count    = 0;
   int unsigned          load_count    = 0;
   int unsigned          found_count   = 0;
   int unsigned          miss_count    = 0;
   int unsigned          length_writes = 0;
   int unsigned          fail_count    = 0;

   wildcard_byte_pattern_scan i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned clamp_length(input logic [CSR_LEN_W-1:0] value);
      if (value == 0) return 1;
      if (value > WIN_DEPTH) return WIN_DEPTH;
      return value;
   endfunction

   function automatic void predict_transfer(input req_type t);
      int unsigned len;
      logic        hit;
      rsp_type     r;
      if (t.action == ACTION_LOAD) begin
         pattern_mem[t.entry_index].wild  = t.entry_wild;
         pattern_mem[t.entry_index].value = t.entry_byte;
         load_count++;
         return;
      end
      scan_count++;
      for (int i = WIN_DEPTH - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
      recent_bytes[0] = t.data_byte;
      if (fill_count < WIN_DEPTH) fill_count++;
      len = clamp_length(scan_len);
      if (!match_reported) begin
         hit = (fill_count >= len);
         for (int i = 0; i < len; i++) begin
            if (!pattern_mem[i].wild && pattern_mem[i].value != recent_bytes[len-1-i]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            match_reported  = 1'b1;
            r.found         = 1'b1;
            r.match_address = t.byte_address - (len - 1);
            pending_matches.push_back(r);
         end else if (t.region_last) begin
            r = '0;
            pending_matches.push_back(r);
         end
      end
      if (t.region_last) begin
         fill_count     = 0;
         match_reported = 1'b0;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset) begin
         foreach (pattern_mem[i]) pattern_mem[i] = '0;
         foreach (recent_bytes[i]) recent_bytes[i] = '0;
         fill_count     = 0;
         match_reported = 1'b0;
         scan_len       = CSR_LEN_RESET;
         pending_matches.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_matches.size() == 0) begin
               $error("result with no transfer pending: found %0b, match_address %h",
                      rsp_data.found, rsp_data.match_address);
               fail_count++;
            end else begin
               want = pending_matches.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0b, actual %0b", want.found, rsp_data.found);
                  fail_count++;
               end
               if (rsp_data.match_address !== want.match_address) begin
                  $error("match_address: expected %h, actual %h",
                         want.match_address, rsp_data.match_address);
                  fail_count++;
               end
               if (want.found) found_count++;
               else miss_count++;
            end
         end
         if (csr_we) scan_len = csr_wdata;
         if (req_valid && req_ready) predict_transfer(req_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready && stall_on) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 5);
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 10);
      end
   end

   initial begin : watchdog
      @(negedge reset);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $error("no transfer for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, pending_matches.size());
      $display("status: fail");
      $finish;
   end

   task automatic send_item(input req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      stim_count++;
   endtask

   task automatic load_entry(input logic [4:0] idx, input logic [7:0] value, input logic wild);
      req_type t;
      t.action       = ACTION_LOAD;
      t.entry_index  = idx;
      t.entry_byte   = value;
      t.entry_wild   = wild;
      t.data_byte    = $urandom;
      t.byte_address = $urandom;
      t.region_last  = $urandom;
      plan_byte[idx] = value;
      plan_wild[idx] = wild;
      send_item(t);
   endtask

   task automatic scan_byte(input logic [7:0] value, input logic [31:0] addr, input logic last);
      req_type t;
      t.action       = ACTION_SCAN;
      t.entry_index  = $urandom;
      t.entry_byte   = $urandom;
      t.entry_wild   = $urandom;
      t.data_byte    = value;
      t.byte_address = addr;
      t.region_last  = last;
      send_item(t);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [CSR_LEN_W-1:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      length_writes++;
   endtask

   // reset pattern: length 1, entry 0 is a literal zero byte
   task automatic test_reset_state();
      scan_byte(8'h00, 32'h0000_0010, 1'b0);
      scan_byte(8'h00, 32'h0000_0011, 1'b0);
      scan_byte(8'hFF, 32'hFFFF_FFFF, 1'b1);
   endtask

   // overlapping candidate: the failing byte must start a new attempt
   task automatic test_overlap_restart();
      write_length(3);
      load_entry(0, 8'hAA, 1'b0);
      load_entry(1, 8'hAA, 1'b0);
      load_entry(2, 8'hAB, 1'b0);
      scan_byte(8'hAA, 32'h0000_0100, 1'b0);
      scan_byte(8'hAA, 32'h0000_0101, 1'b0);
      scan_byte(8'hAA, 32'h0000_0102, 1'b0);
      scan_byte(8'hAB, 32'h0000_0103, 1'b1);
   endtask

   task automatic test_length_limits();
      write_length(0);
      load_entry(0, 8'h00, 1'b1);
      load_entry(31, 8'hFF, 1'b0);
      scan_byte(8'h5A, 32'h0000_0000, 1'b0);
      scan_byte(8'hA5, 32'h0000_0001, 1'b1);
      write_length(63);
      scan_byte(8'hFF, 32'h8000_0000, 1'b1);
   endtask

   task automatic test_pattern_update();
      write_length(2);
      load_entry(1, 8'h00, 1'b0);
      scan_byte(8'h11, 32'h0000_0005, 1'b0);
      load_entry(1, 8'h11, 1'b0);
      scan_byte(8'h11, 32'h0000_0006, 1'b1);
   endtask

   task automatic test_address_wrap();
      scan_byte(8'h42, 32'hFFFF_FFFF, 1'b0);
      scan_byte(8'h11, 32'h0000_0000, 1'b1);
      scan_byte(8'h33, 32'h0000_0007, 1'b1);
   endtask

   task automatic test_random_regions(input int unsigned target);
      int unsigned          stop_at;
      int unsigned          phase_end;
      int unsigned          eff;
      int unsigned          region_len;
      int unsigned          at;
      int                   phase;
      logic [CSR_LEN_W-1:0] setting;
      logic [31:0]          base;
      logic [31:0]          addr;
      logic [7:0]           region_bytes [0:127];
      logic                 tight;
      stop_at = stim_count + target;
      phase   = 0;
      while (stim_count < stop_at) begin
         case (phase)
            0: setting = 1;
            1: setting = 32;
            2: setting = 0;
            3: setting = 63;
            4: setting = 33;
            5: setting = 2;
            default: setting = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                            : $urandom_range(1, 8);
         endcase
         write_length(setting);
         eff      = clamp_length(setting);
         gap_max  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         stall_on = ($urandom_range(0, 3) != 0);
         tight    = $urandom_range(0, 1);
         for (int i = 0; i < eff; i++) load_entry(i, $urandom, $urandom_range(0, 3) == 0);
         repeat ($urandom_range(0, 2)) load_entry($urandom_range(0, 31), $urandom, $urandom);
         phase_end = stim_count + 150;
         while (stim_count < phase_end && stim_count < stop_at) begin
            region_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff)
                                                     : $urandom_range(eff, eff + 30);
            for (int k = 0; k < region_len; k++) begin
               if (tight && $urandom_range(0, 7) != 0) region_bytes[k] = plan_byte[$urandom_range(0, eff - 1)];
               else region_bytes[k] = $urandom;
            end
            repeat ($urandom_range(0, 2)) begin
               if (region_len >= eff) begin
                  at = $urandom_range(0, region_len - eff);
                  for (int i = 0; i < eff; i++) begin
                     if (!plan_wild[i]) region_bytes[at+i] = plan_byte[i];
                  end
                  if ($urandom_range(0, 3) == 0) begin
                     at = at + $urandom_range(0, eff - 1);
                     region_bytes[at] = ~region_bytes[at];
                  end
               end
            end
            base = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
            for (int k = 0; k < region_len; k++) begin
               if ($urandom_range(0, 39) == 0) load_entry($urandom_range(0, 31), $urandom, $urandom);
               addr = base + k;
               if ($urandom_range(0, 49) == 0) addr = $urandom;
               scan_byte(region_bytes[k], addr, k == region_len - 1);
            end
            if ($urandom_range(0, 9) == 0) drain_results();
         end
         phase++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_overlap_restart();
      test_length_limits();
      test_pattern_update();
      test_address_wrap();
      test_random_regions(RANDOM_ITEMS);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d scanned bytes and %0d pattern loads over %0d length settings",
               scan_count, load_count, length_writes);
      $display("checked %0d matches and %0d regions that ended without one",
               found_count, miss_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
